@@ rtl/core/ptw_pkg.sv @@
package ptw_pkg;

   localparam int WORDS_PER_FRAME = 1024;
   localparam int IDX_BITS = 10;
   localparam int OFFSET_BITS = 12;
   localparam int FRAME_NUM_BITS = 20;
   localparam int PC_BITS = 5;

   // Flags written into a directory entry that links a fresh table: present, write, user
   localparam logic [OFFSET_BITS-1:0] TABLE_LINK_FLAGS = 12'h007;

   // Word index of the current-directory register on the control port
   localparam logic CSR_IDX_CUR_DIR = 1'b0;

   typedef enum logic [1:0] {
      OP_MAP    = 2'd0,
      OP_UNMAP  = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [1:0] {
      FRM_DIR,
      FRM_CUR,
      FRM_TABLE,
      FRM_SPARE
   } frame_sel_type;

   typedef enum logic [1:0] {
      IDX_DIR,
      IDX_TAB,
      IDX_CNT
   } idx_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_LINK,
      WD_ENTRY
   } wdata_sel_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_SET_PRESENT,
      RES_SET_CREATED,
      RES_OLD_FRAME,
      RES_TRANSLATE
   } res_sel_type;

   typedef enum logic [2:0] {
      JC_NONE,
      JC_ALWAYS,
      JC_RD_PRESENT,
      JC_RD_ABSENT,
      JC_CNT_MORE
   } jump_cond_type;

   typedef struct packed {
      logic                 mem_rd;
      logic                 mem_wr;
      frame_sel_type        frame_sel;
      idx_sel_type          idx_sel;
      wdata_sel_type        wdata_sel;
      logic                 latch_de;
      res_sel_type          res_sel;
      logic                 cnt_inc;
      jump_cond_type        jump_cond;
      logic [PC_BITS-1:0]   jump_target;
      logic                 emit;
   } ctl_word_type;

   typedef struct packed {
      ctl_word_type ctl;
      logic         start;
      logic         sweeping;
   } seq_ctl_type;

   typedef struct packed {
      logic rd_present;
      logic cnt_more;
      logic sweep_last;
   } dp_status_type;

   // Program step addresses
   localparam logic [PC_BITS-1:0] PC_MAP_READ     = 5'd0;
   localparam logic [PC_BITS-1:0] PC_MAP_TEST     = 5'd1;
   localparam logic [PC_BITS-1:0] PC_MAP_CLEAR    = 5'd2;
   localparam logic [PC_BITS-1:0] PC_MAP_LINK     = 5'd3;
   localparam logic [PC_BITS-1:0] PC_MAP_REREAD   = 5'd4;
   localparam logic [PC_BITS-1:0] PC_MAP_HIT      = 5'd5;
   localparam logic [PC_BITS-1:0] PC_MAP_LATCH    = 5'd6;
   localparam logic [PC_BITS-1:0] PC_MAP_WRITE    = 5'd7;
   localparam logic [PC_BITS-1:0] PC_UNMAP_READ   = 5'd8;
   localparam logic [PC_BITS-1:0] PC_UNMAP_TEST   = 5'd9;
   localparam logic [PC_BITS-1:0] PC_UNMAP_PTE    = 5'd10;
   localparam logic [PC_BITS-1:0] PC_UNMAP_CLEAR  = 5'd11;
   localparam logic [PC_BITS-1:0] PC_LOOKUP_READ  = 5'd12;
   localparam logic [PC_BITS-1:0] PC_LOOKUP_TEST  = 5'd13;
   localparam logic [PC_BITS-1:0] PC_LOOKUP_PTE   = 5'd14;
   localparam logic [PC_BITS-1:0] PC_LOOKUP_XLATE = 5'd15;
   localparam logic [PC_BITS-1:0] PC_EMIT         = 5'd16;

   function automatic logic [PC_BITS-1:0] entry_point(input opcode_type op);
      logic [PC_BITS-1:0] pc;
      case (op)
         OP_MAP:    pc = PC_MAP_READ;
         OP_UNMAP:  pc = PC_UNMAP_READ;
         OP_LOOKUP: pc = PC_LOOKUP_READ;
         default:   pc = PC_EMIT;
      endcase
      return pc;
   endfunction

   function automatic ctl_word_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ctl_word_type w;
      w = '0;
      case (pc)
         PC_MAP_READ: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_DIR;
            w.idx_sel = IDX_DIR;
         end
         PC_MAP_TEST: begin
            w.jump_cond = JC_RD_PRESENT;
            w.jump_target = PC_MAP_HIT;
         end
         PC_MAP_CLEAR: begin
            w.mem_wr = 1'b1;
            w.frame_sel = FRM_SPARE;
            w.idx_sel = IDX_CNT;
            w.wdata_sel = WD_ZERO;
            w.cnt_inc = 1'b1;
            w.jump_cond = JC_CNT_MORE;
            w.jump_target = PC_MAP_CLEAR;
         end
         PC_MAP_LINK: begin
            w.mem_wr = 1'b1;
            w.frame_sel = FRM_DIR;
            w.idx_sel = IDX_DIR;
            w.wdata_sel = WD_LINK;
            w.res_sel = RES_SET_CREATED;
         end
         PC_MAP_REREAD: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_DIR;
            w.idx_sel = IDX_DIR;
            w.jump_cond = JC_ALWAYS;
            w.jump_target = PC_MAP_LATCH;
         end
         PC_MAP_HIT: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_DIR;
            w.idx_sel = IDX_DIR;
            w.res_sel = RES_SET_PRESENT;
         end
         PC_MAP_LATCH: begin
            w.latch_de = 1'b1;
         end
         PC_MAP_WRITE: begin
            w.mem_wr = 1'b1;
            w.frame_sel = FRM_TABLE;
            w.idx_sel = IDX_TAB;
            w.wdata_sel = WD_ENTRY;
            w.jump_cond = JC_ALWAYS;
            w.jump_target = PC_EMIT;
         end
         PC_UNMAP_READ: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_CUR;
            w.idx_sel = IDX_DIR;
         end
         PC_UNMAP_TEST: begin
            w.latch_de = 1'b1;
            w.jump_cond = JC_RD_ABSENT;
            w.jump_target = PC_EMIT;
         end
         PC_UNMAP_PTE: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_TABLE;
            w.idx_sel = IDX_TAB;
            w.res_sel = RES_SET_PRESENT;
         end
         PC_UNMAP_CLEAR: begin
            w.mem_wr = 1'b1;
            w.frame_sel = FRM_TABLE;
            w.idx_sel = IDX_TAB;
            w.wdata_sel = WD_ZERO;
            w.res_sel = RES_OLD_FRAME;
            w.jump_cond = JC_ALWAYS;
            w.jump_target = PC_EMIT;
         end
         PC_LOOKUP_READ: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_DIR;
            w.idx_sel = IDX_DIR;
         end
         PC_LOOKUP_TEST: begin
            w.latch_de = 1'b1;
            w.jump_cond = JC_RD_ABSENT;
            w.jump_target = PC_EMIT;
         end
         PC_LOOKUP_PTE: begin
            w.mem_rd = 1'b1;
            w.frame_sel = FRM_TABLE;
            w.idx_sel = IDX_TAB;
         end
         PC_LOOKUP_XLATE: begin
            w.res_sel = RES_TRANSLATE;
         end
         PC_EMIT: begin
            w.emit = 1'b1;
         end
         default: begin
            w.emit = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/two_level_page_table_walker.sv @@
// Two-level page table walker over an internal store of STORE_FRAMES frames
// of 1024 words. The req_ channel takes one word (map, unmap or lookup); the
// rsp_ channel returns exactly one word per request, in order. The csr_ port
// holds the current-directory frame used by unmap; write it only while idle.
//
// The walk runs the microcode steps, with at most one store access per step.
// Lookup and unmap end after the directory entry test when that entry is
// absent; map builds a new table when it is absent, for which the spare frame
// is zeroed one word per cycle. An unused opcode goes straight to its result.
// A new request can be taken in the cycle after the previous result is loaded
// into the output register, even if rsp_stall still holds that result.
//
// After reset all STORE_FRAMES*1024 words of the store are zeroed one word
// per cycle, with req_stall high; the control port works throughout.
// While rsp_stall is high the result word holds, and a walk that reaches its
// result step waits there until the output register is free.
module two_level_page_table_walker
   import ptw_pkg::*;
#(
   parameter int STORE_FRAMES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [19:0] req_directory_frame,
   input  logic [31:0] req_virtual_address,
   input  logic [19:0] req_physical_frame,
   input  logic [11:0] req_entry_flags,
   input  logic [19:0] req_spare_table_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_physical_address,
   output logic        rsp_was_present,
   output logic        rsp_table_created,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [19:0]   cur_dir_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff;
   logic          rsp_present_ff, rsp_created_ff;

   seq_ctl_type   seq_ctl;
   dp_status_type status;
   logic          out_free;
   logic [31:0]   res_addr;
   logic          res_present, res_created;
   logic          csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit = csr_paddr[2] == CSR_IDX_CUR_DIR;
   assign csr_prdata = csr_hit ? {12'd0, cur_dir_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_dir_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         cur_dir_ff <= csr_pwdata[19:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ptw_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .out_free   (out_free),
      .status     (status),
      .req_stall  (req_stall),
      .seq_ctl    (seq_ctl)
   );

   ptw_datapath #(
      .STORE_FRAMES (STORE_FRAMES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .seq_ctl           (seq_ctl),
      .directory_frame   (req_directory_frame),
      .virtual_address   (req_virtual_address),
      .physical_frame    (req_physical_frame),
      .entry_flags       (req_entry_flags),
      .spare_table_frame (req_spare_table_frame),
      .cur_dir_frame     (cur_dir_ff),
      .status            (status),
      .physical_address  (res_addr),
      .was_present       (res_present),
      .table_created     (res_created)
   );

   always_comb begin
      if (seq_ctl.ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctl.ctl.emit) begin
         rsp_addr_ff <= res_addr;
         rsp_present_ff <= res_present;
         rsp_created_ff <= res_created;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_physical_address = rsp_addr_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_table_created = rsp_created_ff;

endmodule

@@ rtl/core/ptw_sequencer.sv @@
module ptw_sequencer
   import ptw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_opcode,
   input  logic          out_free,
   input  dp_status_type status,
   output logic          req_stall,
   output seq_ctl_type   seq_ctl
);

   seq_state_type      state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   ctl_word_type       word;
   logic               taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_CLEAR;
         pc_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      req_stall = 1'b1;
      seq_ctl = '0;
      word = ucode_rom(pc_ff);
      taken = 1'b0;
      case (word.jump_cond)
         JC_NONE:       taken = 1'b0;
         JC_ALWAYS:     taken = 1'b1;
         JC_RD_PRESENT: taken = status.rd_present;
         JC_RD_ABSENT:  taken = !status.rd_present;
         JC_CNT_MORE:   taken = status.cnt_more;
         default:       taken = 1'b0;
      endcase
      case (state_ff)
         SEQ_CLEAR: begin
            seq_ctl.sweeping = 1'b1;
            if (status.sweep_last) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               seq_ctl.start = 1'b1;
               pc_in = entry_point(opcode_type'(req_opcode));
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            // hold on the emit step until the output register frees up
            if (!(word.emit && !out_free)) begin
               seq_ctl.ctl = word;
               if (word.emit) begin
                  state_in = SEQ_IDLE;
               end else if (taken) begin
                  pc_in = word.jump_target;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = SEQ_CLEAR;
         end
      endcase
   end

endmodule

@@ rtl/core/ptw_datapath.sv @@
module ptw_datapath
   import ptw_pkg::*;
#(
   parameter int STORE_FRAMES = 16
)
(
   input  logic          clock,
   input  logic          reset,
   input  seq_ctl_type   seq_ctl,
   input  logic [19:0]   directory_frame,
   input  logic [31:0]   virtual_address,
   input  logic [19:0]   physical_frame,
   input  logic [11:0]   entry_flags,
   input  logic [19:0]   spare_table_frame,
   input  logic [19:0]   cur_dir_frame,
   output dp_status_type status,
   output logic [31:0]   physical_address,
   output logic          was_present,
   output logic          table_created
);

   localparam int DEPTH = STORE_FRAMES * WORDS_PER_FRAME;
   localparam int FRAME_BITS = $clog2(STORE_FRAMES);
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

   logic [31:0]         mem [0:DEPTH-1];
   logic [31:0]         mem_q_ff;
   logic                range_q_ff;

   logic [19:0]         dir_ff, pfn_ff, spare_ff, de_frame_ff;
   logic [31:0]         va_ff;
   logic [11:0]         flags_ff;
   logic [31:0]         addr_ff;
   logic                present_ff, created_ff;
   logic [IDX_BITS-1:0] cnt_ff;
   logic [AW-1:0]       sweep_ff;

   logic [19:0]         frame;
   logic [IDX_BITS-1:0] idx;
   logic                in_range;
   logic [AW-1:0]       mem_addr;
   logic [31:0]         wdata, rd_word;
   logic                mem_we, mem_re;
   ctl_word_type        ctl;

   assign ctl = seq_ctl.ctl;
   assign rd_word = range_q_ff ? mem_q_ff : 32'd0;

   always_comb begin
      case (ctl.frame_sel)
         FRM_DIR:   frame = dir_ff;
         FRM_CUR:   frame = cur_dir_frame;
         FRM_TABLE: frame = de_frame_ff;
         FRM_SPARE: frame = spare_ff;
         default:   frame = dir_ff;
      endcase
      case (ctl.idx_sel)
         IDX_DIR: idx = va_ff[31:22];
         IDX_TAB: idx = va_ff[21:12];
         IDX_CNT: idx = cnt_ff;
         default: idx = va_ff[31:22];
      endcase
      case (ctl.wdata_sel)
         WD_ZERO:  wdata = 32'd0;
         WD_LINK:  wdata = {spare_ff, TABLE_LINK_FLAGS};
         WD_ENTRY: wdata = {pfn_ff, flags_ff};
         default:  wdata = 32'd0;
      endcase
      // frames beyond the store read as zero and drop writes
      in_range = frame < 20'(STORE_FRAMES);
      if (seq_ctl.sweeping) begin
         mem_addr = sweep_ff;
         mem_we = 1'b1;
         mem_re = 1'b0;
         wdata = 32'd0;
      end else begin
         mem_addr = {frame[FRAME_BITS-1:0], idx};
         mem_we = ctl.mem_wr && in_range;
         mem_re = ctl.mem_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_addr];
         range_q_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (seq_ctl.sweeping) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (seq_ctl.start) begin
            cnt_ff <= '0;
         end else if (ctl.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctl.start) begin
         dir_ff <= directory_frame;
         va_ff <= virtual_address;
         pfn_ff <= physical_frame;
         flags_ff <= entry_flags;
         spare_ff <= spare_table_frame;
         addr_ff <= 32'd0;
         present_ff <= 1'b0;
         created_ff <= 1'b0;
      end else begin
         if (ctl.latch_de) begin
            de_frame_ff <= rd_word[31:12];
         end
         case (ctl.res_sel)
            RES_HOLD: ;
            RES_SET_PRESENT: present_ff <= 1'b1;
            RES_SET_CREATED: created_ff <= 1'b1;
            RES_OLD_FRAME:   addr_ff <= {rd_word[31:12], 12'd0};
            RES_TRANSLATE: begin
               if (rd_word[0]) begin
                  present_ff <= 1'b1;
                  addr_ff <= {rd_word[31:12], va_ff[11:0]};
               end
            end
            default: ;
         endcase
      end
   end

   assign status.rd_present = rd_word[0];
   assign status.cnt_more = cnt_ff != '1;
   assign status.sweep_last = sweep_ff == SWEEP_LAST;

   assign physical_address = addr_ff;
   assign was_present = present_ff;
   assign table_created = created_ff;

endmodule
